[hw/rtl/stl_pkg.sv]
// Shared types, constants and helpers for the sorted timer list.
`default_nettype none
package stl_pkg;
	localparam int TIMER_SLOTS = 16;
	localparam int SLOT_W = $clog2(TIMER_SLOTS);
	localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
	localparam logic [30:0] MAX_INTERVAL_RESET = 31'd3600000;

	localparam logic [1:0] MODE_ADD     = 2'd0;
	localparam logic [1:0] MODE_RESCHED = 2'd1;
	localparam logic [1:0] MODE_DELETE  = 2'd2;
	localparam logic [1:0] MODE_RETIRE  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_RANGE    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_INACTIVE = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] now;
		logic [31:0] interval;
		logic [3:0]  handle;
		logic        keep;
	} stl_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  new_handle;
		logic        head_valid;
		logic [3:0]  head_handle;
		logic [30:0] head_wait;
	} stl_out_t;

	typedef struct packed {
		logic load_in;
		logic check;
		logic scan;
		logic load_out;
	} stl_cmd_t;

	typedef struct packed {
		logic go_scan;
		logic scan_hit;
	} stl_stat_t;

	// time left until deadline; a deadline passed by up to half the range counts as expired
	function automatic logic [30:0] remaining(input logic [31:0] dl, input logic [31:0] now);
		logic [31:0] diff;
		diff = dl - now;
		return diff[31] ? 31'd0 : diff[30:0];
	endfunction
endpackage
`default_nettype wire

[hw/rtl/sorted_timer_list.sv]
// Sorted timer list top level: sequencer plus datapath.
// Usage:
//   in channel (in_valid/in_ready/in_data) takes one command item: add,
//   reschedule, delete or retire the expired head, with the current time.
//   out channel (out_valid/out_ready/out_data) returns one result item per
//   command: status, new handle and the list head after the command.
//   cfg channel writes max_interval; cfg_ready is always high.
// Sequence: an item passes through check and done; commands that (re)arm a timer
//   also walk the ordered list, one list entry per scan step, during the
//   ordered insert. The insert walk over the ordered list sets the rate;
//   one item is in work at a time.
// The result sits in an output register; the next item is accepted while
//   it waits. If the receiver stalls, a finished item holds in the done
//   step until the output register frees up.
// Reset clears the active bits, list length and slot counters and loads
//   max_interval with 3600000; the tables need no clearing.
`default_nettype none
module sorted_timer_list import stl_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire stl_in_t     in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output stl_out_t         out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [30:0] cfg_data
);
	stl_cmd_t  cmd;
	stl_stat_t stat;

	assign cfg_ready = 1'b1;

	stl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.stat(stat), .cmd(cmd)
	);

	stl_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .stat(stat),
		.in_data(in_data),
		.cfg_valid(cfg_valid), .cfg_data(cfg_data),
		.out_data(out_data)
	);
endmodule
`default_nettype wire

[hw/rtl/stl_ctrl.sv]
// Sequencer for the sorted timer list: accept, check, ordered scan, deliver.
`default_nettype none
module stl_ctrl import stl_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire stl_stat_t stat,
	output stl_cmd_t       cmd
);
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CHECK = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0] state_q, state_d;
	logic       out_valid_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d = stat.go_scan ? S_SCAN : S_DONE;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_hit) state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == S_CHECK)
		else $error("accepted item did not enter check");
	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (state_q == S_DONE && (!out_valid_q || out_ready)))
		else $error("result loaded over an untaken one");
	a_rise_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result appeared outside done");
endmodule
`default_nettype wire

[hw/rtl/stl_dp.sv]
// Datapath: timer tables, ordered slot list, free stack and result register.
`default_nettype none
module stl_dp import stl_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire stl_cmd_t    cmd,
	output stl_stat_t        stat,
	input  wire stl_in_t     in_data,
	input  wire logic        cfg_valid,
	input  wire logic [30:0] cfg_data,
	output stl_out_t         out_data
);
	stl_in_t            in_q;
	stl_out_t           out_q;
	logic [30:0]        max_q;
	logic [31:0]        deadline_q [TIMER_SLOTS];
	logic [30:0]        period_q [TIMER_SLOTS];
	logic [SLOT_W-1:0]  order_q [TIMER_SLOTS];
	logic [SLOT_W-1:0]  stack_q [TIMER_SLOTS];
	logic [TIMER_SLOTS-1:0] active_q;
	logic [CNT_W-1:0]   len_q, fc_q, fresh_q, j_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [30:0]        mine_q;
	logic [1:0]         stat_q;
	logic [3:0]         newh_q;

	logic [SLOT_W-1:0]  head_slot, h_idx, chk_slot, scan_slot;
	logic [30:0]        head_rem, scan_rem;
	logic               h_ok, do_add, do_pop, do_fresh, do_rearm, do_free;
	logic [1:0]         chk_status;
	logic               rm_found, scan_end;
	logic [CNT_W-1:0]   rm_pos;

	assign head_slot = order_q[0];
	assign head_rem = remaining(deadline_q[head_slot], in_q.now);
	assign h_idx = SLOT_W'(in_q.handle);
	assign h_ok = (32'(in_q.handle) < TIMER_SLOTS) && active_q[h_idx];

	always_comb begin
		chk_status = ST_OK;
		chk_slot = '0;
		do_add = 1'b0; do_pop = 1'b0; do_fresh = 1'b0;
		do_rearm = 1'b0; do_free = 1'b0;
		case (in_q.mode)
			MODE_ADD: begin
				if (in_q.interval == 32'd0 || in_q.interval > {1'b0, max_q}) begin
					chk_status = ST_RANGE;
				end else if (fc_q != '0) begin
					chk_slot = stack_q[SLOT_W'(fc_q - 1'b1)];
					do_add = 1'b1; do_pop = 1'b1;
				end else if (32'(fresh_q) < TIMER_SLOTS) begin
					chk_slot = SLOT_W'(fresh_q);
					do_add = 1'b1; do_fresh = 1'b1;
				end else begin
					chk_status = ST_FULL;
				end
			end
			MODE_RESCHED, MODE_DELETE: begin
				chk_slot = h_idx;
				if (!h_ok) chk_status = ST_INACTIVE;
				else if (in_q.mode == MODE_RESCHED) do_rearm = 1'b1;
				else do_free = 1'b1;
			end
			default: begin
				chk_slot = head_slot;
				if (len_q == '0 || head_rem != '0) chk_status = ST_INACTIVE;
				else if (in_q.keep) do_rearm = 1'b1;
				else do_free = 1'b1;
			end
		endcase
	end

	// position of the slot in the ordered list, first match
	always_comb begin
		rm_found = 1'b0;
		rm_pos = '0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (order_q[i] == chk_slot && CNT_W'(i) < len_q) begin
				rm_found = 1'b1;
				rm_pos = CNT_W'(i);
			end
		end
	end

	assign scan_end = (j_q >= len_q);
	assign scan_slot = order_q[j_q[SLOT_W-1:0]];
	assign scan_rem = remaining(deadline_q[scan_slot], in_q.now);
	assign stat.go_scan = do_add | do_rearm;
	assign stat.scan_hit = scan_end || (scan_rem > mine_q);
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_INTERVAL_RESET;
			active_q <= '0;
			len_q <= '0;
			fc_q <= '0;
			fresh_q <= '0;
		end else begin
			if (cfg_valid) max_q <= cfg_data;
			if (cmd.check) begin
				if (do_pop) fc_q <= fc_q - 1'b1;
				if (do_fresh) fresh_q <= fresh_q + 1'b1;
				if (do_add) active_q[chk_slot] <= 1'b1;
				if (do_free) begin
					active_q[chk_slot] <= 1'b0;
					if (32'(fc_q) < TIMER_SLOTS) fc_q <= fc_q + 1'b1;
				end
				if ((do_rearm || do_free) && rm_found) len_q <= len_q - 1'b1;
			end
			if (cmd.scan && stat.scan_hit && 32'(len_q) < TIMER_SLOTS)
				len_q <= len_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) in_q <= in_data;
		if (cmd.check) begin
			slot_q <= chk_slot;
			stat_q <= chk_status;
			newh_q <= do_add ? 4'(chk_slot) : 4'd0;
			j_q <= '0;
			if (do_add) begin
				period_q[chk_slot] <= in_q.interval[30:0];
				deadline_q[chk_slot] <= in_q.now + in_q.interval;
				mine_q <= in_q.interval[30:0];
			end
			if (do_rearm) begin
				deadline_q[chk_slot] <= in_q.now + {1'b0, period_q[chk_slot]};
				mine_q <= period_q[chk_slot];
			end
			if (do_free && 32'(fc_q) < TIMER_SLOTS)
				stack_q[fc_q[SLOT_W-1:0]] <= chk_slot;
			if ((do_rearm || do_free) && rm_found) begin
				for (int i = 0; i < TIMER_SLOTS - 1; i++)
					if (CNT_W'(i) >= rm_pos) order_q[i] <= order_q[i + 1];
			end
		end
		if (cmd.scan) begin
			if (stat.scan_hit) begin
				if (32'(len_q) < TIMER_SLOTS) begin
					for (int i = 0; i < TIMER_SLOTS; i++) begin
						if (CNT_W'(i) == j_q) order_q[i] <= slot_q;
						else if (i > 0 && CNT_W'(i) > j_q) order_q[i] <= order_q[i - 1];
					end
				end
			end else begin
				j_q <= j_q + 1'b1;
			end
		end
		if (cmd.load_out) begin
			out_q.status <= stat_q;
			out_q.new_handle <= newh_q;
			out_q.head_valid <= (len_q != '0);
			out_q.head_handle <= (len_q != '0) ? 4'(head_slot) : 4'd0;
			out_q.head_wait <= (len_q != '0) ? head_rem : 31'd0;
		end
	end
endmodule
`default_nettype wire

[verif/sorted_timer_list_test.sv]
// Testbench for the sorted timer list: random and directed timer commands checked against a predictor.
`default_nettype none
module sorted_timer_list_test import stl_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic cfg_valid, cfg_ready;
	logic [30:0] cfg_data;
	stl_in_t in_data;
	stl_out_t out_data;

	sorted_timer_list dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// predictor copy of the timer table
	logic [31:0] tm_deadline [TIMER_SLOTS];
	logic [30:0] tm_period [TIMER_SLOTS];
	logic tm_active [TIMER_SLOTS];
	int tm_order [TIMER_SLOTS];
	int tm_len, tm_free_cnt, tm_fresh;
	int tm_free [TIMER_SLOTS];
	logic [30:0] tm_max_interval;

	stl_in_t cmd_queue [$];
	stl_out_t result_queue [$];
	int send_idle_pct, recv_stall_pct;
	int error_count;
	logic cfg_pending;
	logic [30:0] cfg_value;
	// input item taken at the last rising edge
	logic in_took;

	function automatic logic [30:0] time_left(int s, logic [31:0] t);
		logic [31:0] d;
		d = tm_deadline[s] - t;
		return d[31] ? 31'd0 : d[30:0];
	endfunction

	function automatic void unlink(int s);
		int i;
		for (i = 0; i < tm_len; i++)
			if (tm_order[i] == s) begin
				for (int j = i; j + 1 < tm_len; j++) tm_order[j] = tm_order[j + 1];
				tm_len--;
				return;
			end
	endfunction

	function automatic void arm_timer(int s, logic [31:0] t);
		logic [30:0] mine;
		int pos;
		tm_deadline[s] = t + {1'b0, tm_period[s]};
		mine = time_left(s, t);
		pos = tm_len;
		for (int j = 0; j < tm_len; j++)
			if (time_left(tm_order[j], t) > mine) begin
				pos = j;
				break;
			end
		if (tm_len >= TIMER_SLOTS) return;
		for (int j = tm_len; j > pos; j--) tm_order[j] = tm_order[j - 1];
		tm_order[pos] = s;
		tm_len++;
	endfunction

	function automatic void release_slot(int s);
		unlink(s);
		tm_active[s] = 1'b0;
		if (tm_free_cnt < TIMER_SLOTS) tm_free[tm_free_cnt++] = s;
	endfunction

	function automatic stl_out_t timer_step(stl_in_t c);
		stl_out_t r;
		int s;
		r = '0;
		r.status = ST_OK;
		case (c.mode)
			MODE_ADD: begin
				if (c.interval == 0 || c.interval > {1'b0, tm_max_interval}) r.status = ST_RANGE;
				else if (tm_free_cnt > 0) s = tm_free[--tm_free_cnt];
				else if (tm_fresh < TIMER_SLOTS) s = tm_fresh++;
				else r.status = ST_FULL;
				if (r.status == ST_OK) begin
					r.new_handle = s[3:0];
					tm_period[s] = c.interval[30:0];
					tm_active[s] = 1'b1;
					arm_timer(s, c.now);
				end
			end
			MODE_RESCHED, MODE_DELETE: begin
				if (!tm_active[c.handle]) r.status = ST_INACTIVE;
				else if (c.mode == MODE_RESCHED) begin
					unlink(c.handle);
					arm_timer(c.handle, c.now);
				end else release_slot(c.handle);
			end
			default: begin
				if (tm_len == 0 || time_left(tm_order[0], c.now) != 0) r.status = ST_INACTIVE;
				else begin
					s = tm_order[0];
					if (c.keep) begin
						unlink(s);
						arm_timer(s, c.now);
					end else release_slot(s);
				end
			end
		endcase
		if (tm_len > 0) begin
			r.head_valid = 1'b1;
			r.head_handle = tm_order[0][3:0];
			r.head_wait = time_left(tm_order[0], c.now);
		end
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			out_ready <= 1'b0;
			cfg_valid <= 1'b0;
			cfg_data <= '0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
			if (cfg_valid && cfg_ready) cfg_valid <= 1'b0;
			else if (cfg_pending && !cfg_valid) begin
				cfg_valid <= 1'b1;
				cfg_data <= cfg_value;
			end
			if (!in_valid || in_took) begin
				if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= cmd_queue.pop_front();
				end else in_valid <= 1'b0;
			end
		end
	end

	// monitor: predict at input handshake, check at output handshake
	always @(posedge clk) begin
		if (arst_n) begin
			in_took = in_valid && in_ready;
			if (cfg_valid && cfg_ready) begin
				tm_max_interval = cfg_data;
				cfg_pending = 1'b0;
			end
			if (in_valid && in_ready) result_queue.push_back(timer_step(in_data));
			if (out_valid && out_ready) begin
				if (result_queue.size() == 0) begin
					$display("%t: unexpected result, actual %p", $time, out_data);
					error_count++;
				end else begin
					stl_out_t e;
					e = result_queue.pop_front();
					if (e !== out_data) begin
						$display("%t: mismatch, expected %p, actual %p", $time, e, out_data);
						error_count++;
					end
				end
			end
		end else begin
			in_took = 1'b0;
		end
	end

	task automatic wait_drain();
		while (cmd_queue.size() > 0 || in_valid || result_queue.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_limit(logic [30:0] v);
		cfg_value = v;
		cfg_pending = 1'b1;
		while (cfg_pending) @(posedge clk);
	endtask

	function automatic stl_in_t make_cmd(logic [1:0] m, logic [31:0] t, logic [31:0] iv,
			logic [3:0] h, logic k);
		stl_in_t c;
		c.mode = m; c.now = t; c.interval = iv; c.handle = h; c.keep = k;
		return c;
	endfunction

	// mostly valid traffic around a moving clock, with some noise
	task automatic queue_random(int n, int max_iv);
		logic [31:0] t;
		t = $urandom;
		for (int i = 0; i < n; i++) begin
			int p;
			logic [31:0] iv;
			p = $urandom_range(99);
			t += $urandom_range(3) == 0 ? $urandom : $urandom_range(max_iv);
			iv = $urandom_range(9) == 0 ? $urandom : $urandom_range(max_iv + 1);
			cmd_queue.push_back(make_cmd(p < 40 ? MODE_ADD : p < 55 ? MODE_RESCHED :
				p < 70 ? MODE_DELETE : MODE_RETIRE, t, iv, $urandom, $urandom));
		end
	endtask

	initial begin
		error_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cfg_pending = 1'b0;
		cfg_value = '0;
		tm_max_interval = MAX_INTERVAL_RESET;
		tm_len = 0; tm_free_cnt = 0; tm_fresh = 0;
		foreach (tm_active[i]) begin
			tm_active[i] = 1'b0;
			tm_deadline[i] = '0;
			tm_period[i] = '0;
			tm_order[i] = 0;
			tm_free[i] = 0;
		end
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		#1 arst_n = 1'b1;

		// directed: range errors, empty retire, fill, full, delete/reuse, retire
		cmd_queue.push_back(make_cmd(MODE_RETIRE, 32'd0, 32'd0, 4'd0, 1'b0));
		cmd_queue.push_back(make_cmd(MODE_ADD, 32'd0, 32'd0, 4'd0, 1'b0));
		cmd_queue.push_back(make_cmd(MODE_ADD, 32'd0, 32'd3600001, 4'd0, 1'b0));
		cmd_queue.push_back(make_cmd(MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0, 1'b0));
		cmd_queue.push_back(make_cmd(MODE_DELETE, 32'd0, 32'd0, 4'd15, 1'b0));
		cmd_queue.push_back(make_cmd(MODE_RESCHED, 32'd0, 32'd0, 4'd3, 1'b1));
		for (int i = 0; i < 17; i++)
			cmd_queue.push_back(make_cmd(MODE_ADD, 32'hFFFF_FFF0, i == 0 ? 32'd3600000 :
				32'd1 + (i % 4), 4'd0, 1'b0));
		cmd_queue.push_back(make_cmd(MODE_DELETE, 32'hFFFF_FFF0, 32'd0, 4'd5, 1'b0));
		cmd_queue.push_back(make_cmd(MODE_DELETE, 32'hFFFF_FFF0, 32'd0, 4'd9, 1'b0));
		cmd_queue.push_back(make_cmd(MODE_ADD, 32'hFFFF_FFF1, 32'd2, 4'd0, 1'b0));
		cmd_queue.push_back(make_cmd(MODE_RETIRE, 32'hFFFF_FFF0, 32'd0, 4'd0, 1'b1));
		cmd_queue.push_back(make_cmd(MODE_RETIRE, 32'h8000_0010, 32'd0, 4'd0, 1'b1));
		cmd_queue.push_back(make_cmd(MODE_RETIRE, 32'h8000_0010, 32'd0, 4'd0, 1'b0));
		cmd_queue.push_back(make_cmd(MODE_RESCHED, 32'd5, 32'd0, 4'd2, 1'b0));
		wait_drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = ph == 1 ? 65 : ph == 3 ? 30 : 0;
			recv_stall_pct = ph == 2 ? 65 : ph == 3 ? 30 : 0;
			case (ph)
				0: write_limit(31'd1);
				1: write_limit(31'd50);
				2: write_limit(31'h7FFF_FFFF);
				default: write_limit(31'd1000);
			endcase
			queue_random(ph == 2 ? 400 : 450, ph == 0 ? 3 : ph == 2 ? 2000 : 60);
			wait_drain();
		end
		write_limit(31'd0);
		queue_random(20, 10);
		wait_drain();

		if (error_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire

[files.f]
hw/rtl/stl_pkg.sv
hw/rtl/stl_ctrl.sv
hw/rtl/stl_dp.sv
hw/rtl/sorted_timer_list.sv
verif/sorted_timer_list_test.sv
